// ----- rtl/rsr_pkg.sv -----
// rsr_pkg: shared types and constants of the rtcp sender report generator
// no dependencies; used by every other file of the block

package rsr_pkg;

  localparam int unsigned CFG_IDX_W    = 2;
  localparam int unsigned WORD_W       = 32;
  localparam int unsigned TIME_W       = 63;
  localparam int unsigned BYTES_W      = 16;
  localparam int unsigned JOB_DEPTH    = 2;
  localparam int unsigned REPORT_BYTES = 28;
  localparam int unsigned FRAME_W      = REPORT_BYTES * 8;

  // rtcp sender report header: version 2, packet type 200, length 6 words
  localparam logic [7:0] HDR_VERSION = 8'h80;
  localparam logic [7:0] HDR_PT_SR   = 8'd200;
  localparam logic [7:0] HDR_LEN_HI  = 8'h00;
  localparam logic [7:0] HDR_LEN_LO  = 8'h06;

  // microseconds between 1900 and 1970
  localparam logic [63:0] NTP_OFFSET_US = 64'd2208988800000000;
  localparam int unsigned US_PER_S_W    = 20;
  localparam logic [US_PER_S_W-1:0] US_PER_S = 20'd1000000;

  // floor(2^50 / 10^6), always an underestimate of the true reciprocal
  localparam logic [WORD_W-1:0] US_RECIP = 32'd1125899906;

  localparam logic [WORD_W-1:0] RST_REPORT_INTERVAL = 32'd5000000;
  localparam logic [WORD_W-1:0] RST_JUMP_THRESHOLD  = 32'd1000000;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_SOURCE_ID       = 2'd0,
    CFG_REPORT_INTERVAL = 2'd1,
    CFG_JUMP_THRESHOLD  = 2'd2
  } cfg_idx_t;

  typedef enum logic {
    ACT_PACKET = 1'b0,
    ACT_STAMP  = 1'b1
  } action_t;

  typedef struct packed {
    logic [WORD_W-1:0] source_id;
    logic [WORD_W-1:0] report_interval_us;
    logic [WORD_W-1:0] jump_threshold_us;
  } cfg_t;

  // one pending report, snapshot taken at the timestamp event
  typedef struct packed {
    logic [TIME_W-1:0] wall_time;
    logic [WORD_W-1:0] media_stamp;
    logic [WORD_W-1:0] packets;
    logic [WORD_W-1:0] octets;
  } job_t;

endpackage

// ----- rtl/rsr_if.sv -----
// rsr_if: valid/ready channel interfaces for items, report bytes and config writes
// depends on rsr_pkg for field widths

interface rsr_in_if;
  logic                          valid;
  logic                          ready;
  logic                          action;
  logic [rsr_pkg::BYTES_W-1:0]   packet_bytes;
  logic [rsr_pkg::TIME_W-1:0]    wall_time_us;
  logic [rsr_pkg::WORD_W-1:0]    media_stamp;

  modport source (output valid, action, packet_bytes, wall_time_us, media_stamp,
                  input ready);
  modport sink   (input valid, action, packet_bytes, wall_time_us, media_stamp,
                  output ready);
endinterface

interface rsr_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] report_byte;
  logic       report_last;

  modport source (output valid, report_byte, report_last, input ready);
  modport sink   (input valid, report_byte, report_last, output ready);
endinterface

interface rsr_cfg_if;
  logic                          valid;
  logic                          ready;
  logic [rsr_pkg::CFG_IDX_W-1:0] index;
  logic [rsr_pkg::WORD_W-1:0]    data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

// ----- rtl/rtcp_sender_report_generator.sv -----
// rtcp_sender_report_generator: top level, config registers and front/queue/back wiring
// depends on rsr_pkg, rsr_if, rsr_front, rsr_job_fifo and rsr_back
//
// usage:
//   in_ch   items: action 0 = packet sent (packet_bytes counted), action 1 = timestamp
//           check (wall_time_us, media_stamp). a timestamp check may start a report.
//   out_ch  28-byte rtcp sender report, one byte per transaction, network order,
//           report_last high on the final byte.
//   cfg_ch  register writes: 0 source id, 1 report interval, 2 jump threshold;
//           always ready, other indexes are ignored.
// throughput: one item per cycle while the report queue has room; in_ch.ready
//   drops only while JOB_DEPTH reports are already waiting.
// report path: a due report passes through the queue, then two reciprocal divisions by
//   10^6 (ntp seconds and fraction), then leaves one byte per cycle as out_ch
//   accepts. the next queued report starts only after the previous report's final
//   byte is accepted.
// stall: the output byte holds while out_ch.ready is low; items keep flowing in
//   until the queue fills.
// reset: rst_n synchronous; counters and times go to zero, registers to defaults,
//   queue empties, no report pending.

module rtcp_sender_report_generator #(
  parameter int unsigned JOB_DEPTH = rsr_pkg::JOB_DEPTH
) (
  input logic      clk,
  input logic      rst_n,
  rsr_in_if.sink   in_ch,
  rsr_out_if.source out_ch,
  rsr_cfg_if.sink  cfg_ch
);
  import rsr_pkg::*;

  cfg_t  cfg_r, cfg_nxt;
  logic  job_push;
  logic  job_full;
  logic  job_pop;
  logic  job_empty;
  job_t  push_job;
  job_t  pop_job;

  assign cfg_ch.ready = 1'b1;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_ch.valid) begin
      unique case (cfg_ch.index)
        CFG_SOURCE_ID:       cfg_nxt.source_id          = cfg_ch.data;
        CFG_REPORT_INTERVAL: cfg_nxt.report_interval_us = cfg_ch.data;
        CFG_JUMP_THRESHOLD:  cfg_nxt.jump_threshold_us  = cfg_ch.data;
        default:             cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.source_id          <= '0;
      cfg_r.report_interval_us <= RST_REPORT_INTERVAL;
      cfg_r.jump_threshold_us  <= RST_JUMP_THRESHOLD;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  rsr_front u_front (
    .clk             (clk),
    .rst_n           (rst_n),
    .cfg             (cfg_r),
    .in_valid        (in_ch.valid),
    .in_ready        (in_ch.ready),
    .in_action       (in_ch.action),
    .in_packet_bytes (in_ch.packet_bytes),
    .in_wall_time_us (in_ch.wall_time_us),
    .in_media_stamp  (in_ch.media_stamp),
    .job_full        (job_full),
    .job_push        (job_push),
    .job_data        (push_job)
  );

  rsr_job_fifo #(
    .DEPTH (JOB_DEPTH)
  ) u_job_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (job_push),
    .push_data (push_job),
    .full      (job_full),
    .pop       (job_pop),
    .empty     (job_empty),
    .pop_data  (pop_job)
  );

  rsr_back u_back (
    .clk             (clk),
    .rst_n           (rst_n),
    .source_id       (cfg_r.source_id),
    .job_empty       (job_empty),
    .job_pop         (job_pop),
    .job_data        (pop_job),
    .out_valid       (out_ch.valid),
    .out_ready       (out_ch.ready),
    .out_report_byte (out_ch.report_byte),
    .out_report_last (out_ch.report_last)
  );

endmodule

// ----- rtl/rsr_front.sv -----
// rsr_front: stream tracking, packet/octet counters and report-due decision
// depends on rsr_pkg; pushes report jobs into rsr_job_fifo

module rsr_front (
  input  logic                       clk,
  input  logic                       rst_n,
  input  rsr_pkg::cfg_t              cfg,
  input  logic                       in_valid,
  output logic                       in_ready,
  input  logic                       in_action,
  input  logic [rsr_pkg::BYTES_W-1:0] in_packet_bytes,
  input  logic [rsr_pkg::TIME_W-1:0] in_wall_time_us,
  input  logic [rsr_pkg::WORD_W-1:0] in_media_stamp,
  input  logic                       job_full,
  output logic                       job_push,
  output rsr_pkg::job_t              job_data
);
  import rsr_pkg::*;

  logic [WORD_W-1:0] packets_r, packets_nxt;
  logic [WORD_W-1:0] octets_r, octets_nxt;
  logic [TIME_W-1:0] prev_time_r, prev_time_nxt;
  logic [TIME_W-1:0] last_rpt_r, last_rpt_nxt;

  logic              accept;
  logic [63:0]       jump_diff;
  logic [63:0]       rpt_diff;
  logic              jump_due;
  logic              rpt_due;
  logic              due;

  assign in_ready = !job_full;
  assign accept   = in_valid && in_ready;

  // times stay below 2^63 so the 64-bit difference is exact as signed
  assign jump_diff = {1'b0, in_wall_time_us} - {1'b0, prev_time_r};
  assign rpt_diff  = {1'b0, in_wall_time_us} - {1'b0, last_rpt_r};
  assign jump_due  = !jump_diff[63] && (jump_diff > {32'd0, cfg.jump_threshold_us});
  assign rpt_due   = !rpt_diff[63] && (rpt_diff > {32'd0, cfg.report_interval_us});
  assign due       = jump_due || rpt_due;

  always_comb begin
    packets_nxt   = packets_r;
    octets_nxt    = octets_r;
    prev_time_nxt = prev_time_r;
    last_rpt_nxt  = last_rpt_r;
    job_push      = 1'b0;
    if (accept) begin
      if (in_action == ACT_PACKET) begin
        packets_nxt = packets_r + 32'd1;
        octets_nxt  = octets_r + {16'd0, in_packet_bytes};
      end else begin
        prev_time_nxt = in_wall_time_us;
        if (due) begin
          last_rpt_nxt = in_wall_time_us;
          job_push     = 1'b1;
        end
      end
    end
  end

  assign job_data.wall_time   = in_wall_time_us;
  assign job_data.media_stamp = in_media_stamp;
  assign job_data.packets     = packets_r;
  assign job_data.octets      = octets_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      packets_r   <= '0;
      octets_r    <= '0;
      prev_time_r <= '0;
      last_rpt_r  <= '0;
    end else begin
      packets_r   <= packets_nxt;
      octets_r    <= octets_nxt;
      prev_time_r <= prev_time_nxt;
      last_rpt_r  <= last_rpt_nxt;
    end
  end

endmodule

// ----- rtl/rsr_job_fifo.sv -----
// rsr_job_fifo: short queue of report jobs between front and back
// depends on rsr_pkg for job_t

module rsr_job_fifo #(
  parameter int unsigned DEPTH = rsr_pkg::JOB_DEPTH
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          push,
  input  rsr_pkg::job_t push_data,
  output logic          full,
  input  logic          pop,
  output logic          empty,
  output rsr_pkg::job_t pop_data
);
  import rsr_pkg::*;

  localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
  localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

  job_t             slots_r [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;
  logic             do_push;
  logic             do_pop;

  assign full     = (count_r == CNT_FULL);
  assign empty    = (count_r == '0);
  assign do_push  = push && !full;
  assign do_pop   = pop && !empty;
  assign pop_data = slots_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_LAST) ? '0 : wr_ptr_r + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_LAST) ? '0 : rd_ptr_r + 1'b1;
    end
    if (do_push && !do_pop) begin
      count_nxt = count_r + 1'b1;
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      slots_r[wr_ptr_r] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

endmodule

// ----- rtl/rsr_back.sv -----
// rsr_back: ntp conversion by reciprocal multiply and subtract, report serializer
// depends on rsr_pkg; pops jobs from rsr_job_fifo, drives the report byte stream

module rsr_back (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic [rsr_pkg::WORD_W-1:0] source_id,
  input  logic                       job_empty,
  output logic                       job_pop,
  input  rsr_pkg::job_t              job_data,
  output logic                       out_valid,
  input  logic                       out_ready,
  output logic [7:0]                 out_report_byte,
  output logic                       out_report_last
);
  import rsr_pkg::*;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MUL,
    ST_SCALE,
    ST_SUB,
    ST_FIX,
    ST_SEND
  } state_t;

  localparam logic [4:0]  BYTE_LAST   = 5'(REPORT_BYTES - 1);
  localparam logic [63:0] US_PER_S_64 = {44'd0, US_PER_S};

  state_t              state_r, state_nxt;
  logic [63:0]         num_r, num_nxt;
  logic [63:0]         quo_r, quo_nxt;
  logic [63:0]         prod_r, prod_nxt;
  logic [63:0]         sub_r, sub_nxt;
  logic                fine_r, fine_nxt;
  logic                frac_pass_r, frac_pass_nxt;
  logic [WORD_W-1:0]   secs_r, secs_nxt;
  logic [FRAME_W-1:0]  frame_r, frame_nxt;
  logic [4:0]          byte_cnt_r, byte_cnt_nxt;
  logic                out_valid_r, out_valid_nxt;
  job_t                job_r, job_nxt;

  logic [WORD_W-1:0]   mul_a;
  logic [63:0]         prod;
  logic [63:0]         part;
  logic [63:0]         part_x_us;
  logic                rem_ge;
  logic [63:0]         rem_fix;
  logic [63:0]         quo_fix;

  // coarse pass uses the top word, fine pass the remainder left below 2^35
  assign mul_a = fine_r ? num_r[34:3] : num_r[63:32];
  // 32 by 32 product
  assign prod  = {32'd0, mul_a} * {32'd0, US_RECIP};
  assign part  = fine_r ? {47'd0, prod_r[63:47]} : {18'd0, prod_r[63:18]};
  // one million = 2^20 - 2^16 + 2^14 + 2^9 + 2^6
  assign part_x_us = (part << 20) - (part << 16) + (part << 14) + (part << 9) + (part << 6);

  // after both passes the remainder is below two million
  assign rem_ge  = (num_r >= US_PER_S_64);
  assign rem_fix = rem_ge ? num_r - US_PER_S_64 : num_r;
  assign quo_fix = rem_ge ? quo_r + 64'd1 : quo_r;

  assign job_pop         = (state_r == ST_IDLE) && !job_empty;
  assign out_valid       = out_valid_r;
  assign out_report_byte = frame_r[FRAME_W-1 -: 8];
  assign out_report_last = (byte_cnt_r == BYTE_LAST);

  always_comb begin
    state_nxt     = state_r;
    num_nxt       = num_r;
    quo_nxt       = quo_r;
    prod_nxt      = prod_r;
    sub_nxt       = sub_r;
    fine_nxt      = fine_r;
    frac_pass_nxt = frac_pass_r;
    secs_nxt      = secs_r;
    frame_nxt     = frame_r;
    byte_cnt_nxt  = byte_cnt_r;
    out_valid_nxt = out_valid_r;
    job_nxt       = job_r;
    unique case (state_r)
      ST_IDLE: begin
        if (!job_empty) begin
          job_nxt       = job_data;
          num_nxt       = {1'b0, job_data.wall_time} + NTP_OFFSET_US;
          quo_nxt       = '0;
          fine_nxt      = 1'b0;
          frac_pass_nxt = 1'b0;
          state_nxt     = ST_MUL;
        end
      end
      ST_MUL: begin
        prod_nxt  = prod;
        state_nxt = ST_SCALE;
      end
      ST_SCALE: begin
        sub_nxt   = part_x_us;
        quo_nxt   = quo_r + part;
        state_nxt = ST_SUB;
      end
      ST_SUB: begin
        num_nxt = num_r - sub_r;
        if (fine_r) begin
          state_nxt = ST_FIX;
        end else begin
          fine_nxt  = 1'b1;
          state_nxt = ST_MUL;
        end
      end
      ST_FIX: begin
        if (!frac_pass_r) begin
          // seconds mod 2^32, then divide the remainder scaled by 2^32
          secs_nxt      = quo_fix[31:0];
          num_nxt       = {rem_fix[31:0], 32'd0};
          quo_nxt       = '0;
          fine_nxt      = 1'b0;
          frac_pass_nxt = 1'b1;
          state_nxt     = ST_MUL;
        end else begin
          frame_nxt     = {HDR_VERSION, HDR_PT_SR, HDR_LEN_HI, HDR_LEN_LO,
                           source_id, secs_r, quo_fix[31:0], job_r.media_stamp,
                           job_r.packets, job_r.octets};
          byte_cnt_nxt  = '0;
          out_valid_nxt = 1'b1;
          state_nxt     = ST_SEND;
        end
      end
      ST_SEND: begin
        if (out_ready) begin
          frame_nxt    = {frame_r[FRAME_W-9:0], 8'h00};
          byte_cnt_nxt = byte_cnt_r + 5'd1;
          if (byte_cnt_r == BYTE_LAST) begin
            out_valid_nxt = 1'b0;
            state_nxt     = ST_IDLE;
          end
        end
      end
      default: begin
        state_nxt     = ST_IDLE;
        out_valid_nxt = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
      byte_cnt_r  <= '0;
      fine_r      <= 1'b0;
      frac_pass_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      byte_cnt_r  <= byte_cnt_nxt;
      fine_r      <= fine_nxt;
      frac_pass_r <= frac_pass_nxt;
    end
  end

  always_ff @(posedge clk) begin
    num_r   <= num_nxt;
    quo_r   <= quo_nxt;
    prod_r  <= prod_nxt;
    sub_r   <= sub_nxt;
    secs_r  <= secs_nxt;
    frame_r <= frame_nxt;
    job_r   <= job_nxt;
  end

endmodule
